[rtl/float32_multiplier_unit_macros.svh]
// Assertion macros for the binary32 multiplier unit.
// Included by the top level; no other dependencies.
`ifndef FLOAT32_MULTIPLIER_UNIT_MACROS_SVH
`define FLOAT32_MULTIPLIER_UNIT_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define FMU_ASSERT_IMPL(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define FMU_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fmu_pkg.sv]
// Package for the binary32 multiplier: field widths and constants.
// No dependencies.
`timescale 1ns / 1ps
package fmu_pkg;
    localparam int WORD_W   = 32;
    localparam int EXP_W    = 8;
    localparam int FRAC_W   = 23;
    localparam int SIG_W    = FRAC_W + 1;
    localparam int PROD_W   = 2 * SIG_W;
    localparam logic [EXP_W:0] EXP_BIAS = 9'd127;
    localparam int STAGES   = 3;
endpackage

[rtl/fmu_mult.sv]
// Pipelined 24x24 significand multiplier: 24x12 partial products, then a sum.
// Depends on fmu_pkg.
`timescale 1ns / 1ps
module fmu_mult (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [fmu_pkg::SIG_W-1:0]   sig_a,
    input  logic [fmu_pkg::SIG_W-1:0]   sig_b,
    output logic [fmu_pkg::PROD_W-1:0]  prod
);
    import fmu_pkg::*;
    localparam int HALF = SIG_W / 2;

    logic [SIG_W+HALF-1:0] lo_reg, hi_reg;
    logic [PROD_W-1:0]     prod_reg;

    // Form two partial products on the low and high halves of b.
    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= {{HALF{1'b0}}, sig_a} * {{SIG_W{1'b0}}, sig_b[HALF-1:0]};
            hi_reg <= {{HALF{1'b0}}, sig_a} * {{SIG_W{1'b0}}, sig_b[SIG_W-1:HALF]};
        end
    end

    // Add the aligned partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= {{(PROD_W-SIG_W-HALF){1'b0}}, lo_reg}
                      + {hi_reg, {HALF{1'b0}}};
        end
    end

    assign prod = prod_reg;
endmodule

[rtl/float32_multiplier_unit.sv]
// Binary32 multiply unit with valid/ready handshake, three stages deep.
// One item per cycle while the output is taken; the significand multiplier (two
// registered steps) and one normalize-and-round step set the depth. Ready
// drops only when the last stage is full and not taken. Rounding is half-up
// on one guard bit; a zero exponent field gives a signed zero; specials,
// overflow and underflow are not flagged and the exponent wraps modulo 256.
// Depends on fmu_pkg, fmu_mult and float32_multiplier_unit_macros.svh.
`timescale 1ns / 1ps
`include "float32_multiplier_unit_macros.svh"
module float32_multiplier_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fmu_pkg::WORD_W-1:0]  s_operand_a,
    input  logic [fmu_pkg::WORD_W-1:0]  s_operand_b,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fmu_pkg::WORD_W-1:0]  m_product
);
    import fmu_pkg::*;

    logic [STAGES-1:0] vld_reg;
    logic              en;
    // Side data through stages 1..2, aligned with the multiplier
    logic              sgn1_reg, sgn2_reg;
    logic              zero1_reg, zero2_reg;
    logic [EXP_W:0]    exp1_reg, exp2_reg;
    logic [PROD_W-1:0] prod;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [SIG_W-1:0]  kept, low24;
    logic              top;
    logic [EXP_W:0]    expo;
    logic [FRAC_W-1:0] frac;

    // Whole pipe advances unless output holds an untaken item.
    assign en      = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    // Stage 1: sign, zero flag, biased exponent sum; stage 2 holds them.
    always_ff @(posedge aclk) begin
        if (en) begin
            sgn1_reg  <= s_operand_a[WORD_W-1] ^ s_operand_b[WORD_W-1];
            zero1_reg <= (s_operand_a[WORD_W-2:FRAC_W] == '0)
                      || (s_operand_b[WORD_W-2:FRAC_W] == '0);
            exp1_reg  <= {1'b0, s_operand_a[WORD_W-2:FRAC_W]}
                       + {1'b0, s_operand_b[WORD_W-2:FRAC_W]} - EXP_BIAS;
            sgn2_reg  <= sgn1_reg;  zero2_reg <= zero1_reg;  exp2_reg <= exp1_reg;
        end
    end

    fmu_mult u_mult (
        .aclk  (aclk),
        .en    (en),
        .sig_a ({1'b1, s_operand_a[FRAC_W-1:0]}),
        .sig_b ({1'b1, s_operand_b[FRAC_W-1:0]}),
        .prod  (prod)
    );

    // Stage 3: normalize, round half-up, pack.
    always_comb begin
        top      = prod[PROD_W-1];
        low24    = prod[PROD_W-3:FRAC_W-1];
        kept     = top ? prod[PROD_W-2:FRAC_W] : low24;
        frac     = kept[SIG_W-1:1] + {{(FRAC_W-1){1'b0}}, kept[0]};
        expo     = exp2_reg + {{EXP_W{1'b0}}, (top || (low24 == '1))};
        res_next = zero2_reg ? {sgn2_reg, {(WORD_W-1){1'b0}}}
                             : {sgn2_reg, expo[EXP_W-1:0], frac};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign m_valid   = vld_reg[STAGES-1];
    assign m_product = res_reg;

    `FMU_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "ready low with empty output")
    `FMU_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_product) && $stable(vld_reg), "stalled pipe moved")
    `FMU_ASSERT_NEXT(a_advance, aclk, aresetn, s_valid && s_ready, vld_reg[0], "accepted item not in stage one")
endmodule

[bench/float32_multiplier_unit_checker.sv]
// Checker for the binary32 multiply unit: watches both channels, predicts
// each product and compares it with what the unit returns. Depends on fmu_pkg.
`timescale 1ns / 1ps
module float32_multiplier_unit_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [fmu_pkg::WORD_W-1:0]  s_operand_a,
    input  logic [fmu_pkg::WORD_W-1:0]  s_operand_b,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [fmu_pkg::WORD_W-1:0]  m_product,
    output int                          error_count,
    output int                          pending_count
);
    import fmu_pkg::*;

    logic [WORD_W-1:0] product_queue[$];

    // Multiply two binary32 patterns: half-up on one guard bit, wrapped exponent
    function automatic logic [WORD_W-1:0] mul_f32(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic              sgn;
        logic [EXP_W-1:0]  ea;
        logic [EXP_W-1:0]  eb;
        logic [SIG_W-1:0]  ma;
        logic [SIG_W-1:0]  mb;
        logic [PROD_W-1:0] prod;
        logic              top;
        logic [SIG_W-1:0]  low24;
        logic [SIG_W-1:0]  kept;
        logic [FRAC_W-1:0] frac;
        logic [EXP_W:0]    expo;
        sgn   = a[31] ^ b[31];
        ea    = a[30:23];
        eb    = b[30:23];
        ma    = {1'b1, a[FRAC_W-1:0]};
        mb    = {1'b1, b[FRAC_W-1:0]};
        prod  = PROD_W'(ma) * PROD_W'(mb);
        top   = prod[PROD_W-1];
        low24 = prod[45:22];
        kept  = top ? prod[46:23] : low24;
        frac  = kept[SIG_W-1:1] + FRAC_W'(kept[0]);
        expo  = {1'b0, ea} + {1'b0, eb} - EXP_BIAS;
        if (top || low24 == {SIG_W{1'b1}}) begin
            expo = expo + 9'd1;
        end
        if (ea == '0 || eb == '0) begin
            return {sgn, 31'd0};
        end
        return {sgn, expo[EXP_W-1:0], frac};
    endfunction

    assign pending_count = product_queue.size();

    // Predict on each accepted input item, compare on each accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            error_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                product_queue.push_back(mul_f32(s_operand_a, s_operand_b));
            end
            if (m_valid && m_ready) begin
                if (product_queue.size() == 0) begin
                    if (error_count < 10) begin
                        $display("unexpected result %h", m_product);
                    end
                    error_count <= error_count + 1;
                end else begin
                    if (m_product !== product_queue[0]) begin
                        if (error_count < 10) begin
                            $display("product mismatch: expected %h actual %h",
                                     product_queue[0], m_product);
                        end
                        error_count <= error_count + 1;
                    end
                    void'(product_queue.pop_front());
                end
            end
        end
    end
endmodule

[bench/float32_multiplier_unit_tb.sv]
// Testbench top for the binary32 multiply unit: clock, reset, stimulus and
// verdict. Depends on fmu_pkg, float32_multiplier_unit and its checker.
`timescale 1ns / 1ps
module float32_multiplier_unit_tb;
    import fmu_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [WORD_W-1:0] s_operand_a = '0;
    logic [WORD_W-1:0] s_operand_b = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [WORD_W-1:0] m_product;
    int                error_count;
    int                pending_count;
    bit                hold_results = 1'b0;
    bit                stim_done = 1'b0;
    bit                rx_burst = 1'b0;

    always #2 aclk = ~aclk;

    float32_multiplier_unit dut (.*);

    float32_multiplier_unit_checker checker_i (.*);

    // Send one item, then wait the drawn gap
    task automatic send_item(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                             input int gap);
        s_valid     <= 1'b1;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Build a pattern from sign, exponent and fraction
    function automatic logic [WORD_W-1:0] pack(input logic s, input logic [7:0] e,
                                               input logic [22:0] f);
        return {s, e, f};
    endfunction

    // Draw an operand: mostly normal numbers, sometimes edge exponents
    function automatic logic [WORD_W-1:0] rand_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return pack(1'($urandom), 8'd0, 23'($urandom));
            1: return pack(1'($urandom), 8'd255, 23'($urandom));
            2: return pack(1'($urandom), 8'($urandom), 23'h7FFFFF);
            3: return pack(1'($urandom), 8'($urandom_range(1, 20)), 23'($urandom));
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial begin
        int gap_max;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: extremes, zero exponents, specials, wrap and rounding carry
        send_item(32'h0000_0000, 32'h3F80_0000, 0);
        send_item(32'h8000_0000, 32'h3F80_0000, 1);
        send_item(32'h3F80_0000, 32'h807F_FFFF, 0);
        send_item(32'h3F80_0000, 32'h3F80_0000, 0);
        send_item(32'hBFC0_0000, 32'h4000_0000, 2);
        send_item(32'h7F80_0000, 32'h3F80_0000, 0);
        send_item(32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_item(32'h7F7F_FFFF, 32'h7F7F_FFFF, 0);
        send_item(32'h0080_0000, 32'h0080_0000, 0);
        send_item(32'h3FFF_FFFF, 32'h3F80_0001, 0);
        send_item(32'h3FBF_FFFF, 32'h3F80_0001, 0);
        send_item(32'h3FFF_FFFF, 32'h3FFF_FFFF, 0);
        send_item(32'h3F80_0001, 32'h3F80_0001, 0);
        send_item(32'h3FB5_04F3, 32'h3FB5_04F3, 0);
        send_item(32'hFFFF_FFFF, 32'h0000_0001, 0);
        send_item(32'h5555_5555, 32'hAAAA_AAAA, 3);
        // Pause until every expected result has come
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        // Fill the pipe while the receiver holds off
        hold_results <= 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_item($urandom, $urandom, 0);
        end
        for (int i = 0; i < 1050; i++) begin
            gap_max = ((i / 150) % 2 == 0) ? 13 : 0;
            send_item(rand_operand(), rand_operand(), $urandom_range(0, gap_max));
        end
        s_valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // Receiver: random stalls, one long hold-off once the fill phase starts
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_results && !rx_burst) begin
                rx_burst = 1'b1;
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Verdict
    initial begin
        wait (stim_done);
        while (pending_count != 0) @(posedge aclk);
        repeat (STAGES + 10) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Timeout
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
